[design/rsqe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Residual scalar quantize encoder package
// Shared widths, operation codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package rsqe_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int NARROW_ENTRIES      = 16;
   localparam int VALUE_W             = 32;
   localparam int INDEX_W             = 8;
   localparam int CODE_W              = 8;
   localparam int NIBBLE_W            = 4;
   localparam int DOT_W               = 64;
   localparam int CORR_W              = 48;
   localparam int CORR_SHIFT          = 15;
   localparam logic WIDE_CODES_RESET  = 1'b1;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_ENCODE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[design/rsqe_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Centroid table memory
// One write port and two registered read ports for neighboring entries.
// ----------------------------------------------------------------------------
module rsqe_table #(
   parameter int TABLE_DEPTH = rsqe_pkg::TABLE_DEPTH_DEFAULT,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [AW-1:0]                        wr_addr,
   input  wire logic signed [rsqe_pkg::VALUE_W-1:0] wr_data,
   input  wire logic [AW-1:0]                        rd_addr_a,
   input  wire logic [AW-1:0]                        rd_addr_b,
   output logic signed [rsqe_pkg::VALUE_W-1:0]      rd_data_a,
   output logic signed [rsqe_pkg::VALUE_W-1:0]      rd_data_b
);

   logic signed [rsqe_pkg::VALUE_W-1:0] mem_ff [TABLE_DEPTH];
   logic signed [rsqe_pkg::VALUE_W-1:0] rd_a_ff;
   logic signed [rsqe_pkg::VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

[design/residual_scalar_quantize_encoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Residual scalar quantize encoder
// Nearest-centroid coding of one residual dimension per beat, code packing
// and a saturated dot-product correction at vector end.
// ----------------------------------------------------------------------------
// A load beat writes one centroid. An encode beat runs a binary search over
// the ascending table, one midpoint compare per cycle with both neighboring
// entries from the registered read ports, then the multiply, accumulate and
// output states. The result sits in an output register, so the next beat is
// taken while it still waits. There is no clearing pass after reset.
module residual_scalar_quantize_encoder_unit #(
   parameter int TABLE_DEPTH = rsqe_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_wide_codes,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_op,
   input  wire logic [rsqe_pkg::INDEX_W-1:0]        req_table_index,
   input  wire logic signed [rsqe_pkg::VALUE_W-1:0] req_table_value,
   input  wire logic signed [rsqe_pkg::VALUE_W-1:0] req_target_value,
   input  wire logic signed [rsqe_pkg::VALUE_W-1:0] req_recon_value,
   input  wire logic                                 req_last_dim,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [rsqe_pkg::CODE_W-1:0]              rsp_code,
   output logic [rsqe_pkg::CODE_W-1:0]              rsp_packed_byte,
   output logic                                      rsp_byte_ready,
   output logic signed [rsqe_pkg::CORR_W-1:0]       rsp_correction,
   output logic                                      rsp_vector_done
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int VW = rsqe_pkg::VALUE_W;
   localparam int DW = rsqe_pkg::DOT_W;
   localparam int CW = rsqe_pkg::CORR_W;
   localparam int NW = rsqe_pkg::NIBBLE_W;
   localparam logic signed [DW-1:0] DOT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DOT_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [CW-1:0] CORR_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CORR_MIN = {1'b1, {(CW-1){1'b0}}};

   rsqe_pkg::state_type state_ff, state_in;

   logic                  wide_ff;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic signed [VW:0]    resid_ff;
   logic signed [VW-1:0]  recon_ff;
   logic                  last_ff;
   logic signed [DW-1:0]  product_ff;
   logic signed [DW-1:0]  dot_ff, dot_in;
   logic                  phase_ff;
   logic [NW-1:0]         low_nib_ff;

   logic                              rsp_valid_ff;
   logic [rsqe_pkg::CODE_W-1:0]      code_ff;
   logic [rsqe_pkg::CODE_W-1:0]      byte_ff;
   logic                              ready_ff;
   logic signed [CW-1:0]             corr_ff;
   logic                              done_ff;

   logic                  req_accept;
   logic                  encode_start;
   logic                  load_write;
   logic                  search_en;
   logic                  mul_en;
   logic                  acc_en;
   logic                  done_stage;
   logic                  slot_free;
   logic                  out_load;

   logic [AW-1:0]         hi_init;
   logic [AW:0]           mid_sum_cur;
   logic [AW-1:0]         mid_cur;
   logic [AW:0]           mid_sum_in;
   logic [AW-1:0]         mid_in;
   logic                  search_go;
   logic [AW-1:0]         rd_addr_a;
   logic [AW-1:0]         rd_addr_b;
   logic signed [VW-1:0]  rd_data_a;
   logic signed [VW-1:0]  rd_data_b;
   logic signed [VW+1:0]  twice_resid;
   logic signed [VW+1:0]  mid_bound;
   logic signed [DW-1:0]  mul_full;
   logic signed [DW:0]    acc_sum;
   logic signed [DW-1:0]  dot_shift;
   logic signed [CW-1:0]  corr_sat;

   logic [rsqe_pkg::CODE_W-1:0] code_val;
   logic [NW-1:0]               nib_val;
   logic [rsqe_pkg::CODE_W-1:0] byte_val;
   logic                        ready_val;
   logic                        phase_val;
   logic [NW-1:0]               low_nib_val;

   assign csr_ready    = 1'b1;
   assign req_stall    = (state_ff != rsqe_pkg::ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign encode_start = req_accept && (req_op == rsqe_pkg::OP_ENCODE);
   assign load_write   = req_accept && (req_op == rsqe_pkg::OP_LOAD)
                         && ({1'b0, req_table_index} < (rsqe_pkg::INDEX_W+1)'(TABLE_DEPTH));
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign out_load     = done_stage && slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsqe_pkg::ST_IDLE: begin
            if (encode_start) begin
               state_in = rsqe_pkg::ST_SEARCH;
            end
         end
         rsqe_pkg::ST_SEARCH: begin
            if (!search_go) begin
               state_in = rsqe_pkg::ST_MUL;
            end
         end
         rsqe_pkg::ST_MUL: begin
            state_in = rsqe_pkg::ST_ACC;
         end
         rsqe_pkg::ST_ACC: begin
            state_in = rsqe_pkg::ST_DONE;
         end
         rsqe_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = rsqe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsqe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      search_en  = 1'b0;
      mul_en     = 1'b0;
      acc_en     = 1'b0;
      done_stage = 1'b0;
      unique case (state_ff)
         rsqe_pkg::ST_IDLE:   begin end
         rsqe_pkg::ST_SEARCH: search_en  = 1'b1;
         rsqe_pkg::ST_MUL:    mul_en     = 1'b1;
         rsqe_pkg::ST_ACC:    acc_en     = 1'b1;
         rsqe_pkg::ST_DONE:   done_stage = 1'b1;
         default:             begin end
      endcase
   end

   // Search step: compare twice the residual with the sum of two neighbors.
   assign hi_init     = wide_ff ? AW'(TABLE_DEPTH - 1) : AW'(rsqe_pkg::NARROW_ENTRIES - 1);
   assign mid_sum_cur = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_cur     = mid_sum_cur[AW:1];
   assign twice_resid = {resid_ff, 1'b0};
   assign mid_bound   = (VW+2)'(rd_data_a) + (VW+2)'(rd_data_b);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (encode_start) begin
         lo_in = '0;
         hi_in = hi_init;
      end else if (search_en) begin
         if (twice_resid < mid_bound) begin
            hi_in = mid_cur;
         end else begin
            lo_in = mid_cur + AW'(1);
         end
      end
   end

   assign mid_sum_in = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in     = mid_sum_in[AW:1];
   assign search_go  = lo_in < hi_in;
   assign rd_addr_a  = search_go ? mid_in : lo_in;
   assign rd_addr_b  = mid_in + AW'(1);

   rsqe_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (load_write),
      .wr_addr   (req_table_index[AW-1:0]),
      .wr_data   (req_table_value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign mul_full = recon_ff * rd_data_a;
   assign acc_sum  = (DW+1)'(dot_ff) + (DW+1)'(product_ff);

   always_comb begin
      dot_in = dot_ff;
      if (acc_en) begin
         if (acc_sum[DW] != acc_sum[DW-1]) begin
            dot_in = acc_sum[DW] ? DOT_MIN : DOT_MAX;
         end else begin
            dot_in = acc_sum[DW-1:0];
         end
      end else if (out_load && last_ff) begin
         dot_in = '0;
      end
   end

   assign dot_shift = dot_ff >>> rsqe_pkg::CORR_SHIFT;

   always_comb begin
      if ((&dot_shift[DW-1:CW-1]) || !(|dot_shift[DW-1:CW-1])) begin
         corr_sat = dot_shift[CW-1:0];
      end else begin
         corr_sat = dot_shift[DW-1] ? CORR_MIN : CORR_MAX;
      end
   end

   // Code packing: low nibble first in narrow mode, a pending nibble is
   // flushed on the last dimension.
   assign code_val = rsqe_pkg::CODE_W'(lo_ff);
   assign nib_val  = code_val[NW-1:0];

   always_comb begin
      byte_val    = '0;
      ready_val   = 1'b0;
      phase_val   = phase_ff;
      low_nib_val = low_nib_ff;
      if (wide_ff) begin
         byte_val  = code_val;
         ready_val = 1'b1;
         phase_val = 1'b0;
      end else if (!phase_ff) begin
         low_nib_val = nib_val;
         if (last_ff) begin
            byte_val  = {{NW{1'b0}}, nib_val};
            ready_val = 1'b1;
         end else begin
            phase_val = 1'b1;
         end
      end else begin
         byte_val  = {nib_val, low_nib_ff};
         ready_val = 1'b1;
         phase_val = 1'b0;
      end
      if (last_ff) begin
         phase_val   = 1'b0;
         low_nib_val = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsqe_pkg::ST_IDLE;
         wide_ff      <= rsqe_pkg::WIDE_CODES_RESET;
         dot_ff       <= '0;
         phase_ff     <= 1'b0;
         low_nib_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dot_ff   <= dot_in;
         if (csr_valid && csr_ready) begin
            wide_ff <= csr_wide_codes;
         end
         if (out_load) begin
            phase_ff   <= phase_val;
            low_nib_ff <= low_nib_val;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (encode_start) begin
         resid_ff <= (VW+1)'(req_target_value) - (VW+1)'(req_recon_value);
         recon_ff <= req_recon_value;
         last_ff  <= req_last_dim;
      end
      if (mul_en) begin
         product_ff <= mul_full;
      end
      if (out_load) begin
         code_ff <= code_val;
         byte_ff <= byte_val;
         ready_ff <= ready_val;
         corr_ff <= last_ff ? corr_sat : '0;
         done_ff <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code        = code_ff;
   assign rsp_packed_byte = byte_ff;
   assign rsp_byte_ready  = ready_ff;
   assign rsp_correction  = corr_ff;
   assign rsp_vector_done = done_ff;

endmodule
`default_nettype wire

[design/rsqe_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Residual scalar quantize encoder checker
// Port-level properties of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rsqe_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 csr_valid,
   input wire logic                                 csr_ready,
   input wire logic                                 csr_wide_codes,
   input wire logic                                 req_valid,
   input wire logic                                 req_stall,
   input wire logic                                 req_op,
   input wire logic [rsqe_pkg::INDEX_W-1:0]        req_table_index,
   input wire logic signed [rsqe_pkg::VALUE_W-1:0] req_table_value,
   input wire logic signed [rsqe_pkg::VALUE_W-1:0] req_target_value,
   input wire logic signed [rsqe_pkg::VALUE_W-1:0] req_recon_value,
   input wire logic                                 req_last_dim,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_stall,
   input wire logic [rsqe_pkg::CODE_W-1:0]         rsp_code,
   input wire logic [rsqe_pkg::CODE_W-1:0]         rsp_packed_byte,
   input wire logic                                 rsp_byte_ready,
   input wire logic signed [rsqe_pkg::CORR_W-1:0]  rsp_correction,
   input wire logic                                 rsp_vector_done
);

   // An encode beat keeps the input side busy for the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == rsqe_pkg::OP_ENCODE) |=> req_stall)
      else $error("encode beat did not occupy the encoder");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code)
         && $stable(rsp_packed_byte) && $stable(rsp_correction))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_vector_done |-> rsp_correction == '0)
      else $error("correction given before vector end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vector_done |-> rsp_byte_ready)
      else $error("vector end left a code byte unfinished");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_ready |-> rsp_packed_byte == '0)
      else $error("packed byte nonzero without a finished byte");

endmodule

bind residual_scalar_quantize_encoder_unit rsqe_checker u_rsqe_checker (.*);
`default_nettype wire

[bench/rsqe_encode_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Residual scalar quantize encoder checker
// Watches the request, result and register channels of the encoder, keeps its
// own copy of the centroid table, accumulator and nibble packer, predicts the
// result of every accepted encode beat and compares each accepted result beat
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rsqe_encode_checker #(
   parameter int TABLE_DEPTH = rsqe_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic                                 csr_wide_codes,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [rsqe_pkg::INDEX_W-1:0]        req_table_index,
   input  logic signed [rsqe_pkg::VALUE_W-1:0] req_table_value,
   input  logic signed [rsqe_pkg::VALUE_W-1:0] req_target_value,
   input  logic signed [rsqe_pkg::VALUE_W-1:0] req_recon_value,
   input  logic                                 req_last_dim,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [rsqe_pkg::CODE_W-1:0]         rsp_code,
   input  logic [rsqe_pkg::CODE_W-1:0]         rsp_packed_byte,
   input  logic                                 rsp_byte_ready,
   input  logic signed [rsqe_pkg::CORR_W-1:0]  rsp_correction,
   input  logic                                 rsp_vector_done,
   output int                                   mismatch_count,
   output int                                   pending_results
);

   typedef struct packed {
      logic [rsqe_pkg::CODE_W-1:0]        code;
      logic [rsqe_pkg::CODE_W-1:0]        packed_byte;
      logic                               byte_ready;
      logic signed [rsqe_pkg::CORR_W-1:0] correction;
      logic                               vector_done;
   } encoding_type;

   localparam longint ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN  = -ACC_MAX - 1;
   localparam longint CORR_MAX = (longint'(1) <<< (rsqe_pkg::CORR_W - 1)) - 1;
   localparam longint CORR_MIN = -CORR_MAX - 1;

   int           centroid_mirror [TABLE_DEPTH];
   longint       dot_acc;
   logic         nib_pending;
   logic [3:0]   nib_low;
   logic         wide_mode;
   encoding_type expected_encodings [$];
   int           failures;
   int           results_seen;

   function automatic int unsigned nearest_centroid(longint residual, int unsigned entries);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      longint      twice;
      longint      boundary;
      lo    = 0;
      hi    = entries - 1;
      twice = residual * 2;
      while (lo < hi) begin
         mid      = (lo + hi) / 2;
         boundary = longint'(centroid_mirror[mid]) + longint'(centroid_mirror[mid + 1]);
         if (twice < boundary) begin
            hi = mid;
         end else begin
            lo = mid + 1;
         end
      end
      return lo;
   endfunction

   task automatic predict_encoding(input logic signed [rsqe_pkg::VALUE_W-1:0] target,
                                   input logic signed [rsqe_pkg::VALUE_W-1:0] recon,
                                   input logic last);
      encoding_type res;
      longint       residual;
      longint       product;
      longint       corr;
      int unsigned  entries;
      int unsigned  k;
      residual = longint'(target) - longint'(recon);
      entries  = wide_mode ? 256 : rsqe_pkg::NARROW_ENTRIES;
      if (entries > TABLE_DEPTH) begin
         entries = TABLE_DEPTH;
      end
      k        = nearest_centroid(residual, entries) & 8'hFF;
      res      = '0;
      res.code = k[7:0];
      if (wide_mode) begin
         nib_pending     = 1'b0;
         res.packed_byte = k[7:0];
         res.byte_ready  = 1'b1;
      end else if (!nib_pending) begin
         nib_low = k[3:0];
         if (last) begin
            res.packed_byte = {4'h0, nib_low};
            res.byte_ready  = 1'b1;
         end else begin
            nib_pending = 1'b1;
         end
      end else begin
         res.packed_byte = {k[3:0], nib_low};
         res.byte_ready  = 1'b1;
         nib_pending     = 1'b0;
      end
      product = longint'(recon) * longint'(centroid_mirror[k]);
      if (product > 0 && dot_acc > ACC_MAX - product) begin
         dot_acc = ACC_MAX;
      end else if (product < 0 && dot_acc < ACC_MIN - product) begin
         dot_acc = ACC_MIN;
      end else begin
         dot_acc = dot_acc + product;
      end
      if (last) begin
         corr = dot_acc >>> rsqe_pkg::CORR_SHIFT;
         if (corr > CORR_MAX) begin
            corr = CORR_MAX;
         end
         if (corr < CORR_MIN) begin
            corr = CORR_MIN;
         end
         res.correction = corr[rsqe_pkg::CORR_W-1:0];
         dot_acc        = 0;
         nib_pending    = 1'b0;
         nib_low        = 4'h0;
      end
      res.vector_done = last;
      expected_encodings.insert(expected_encodings.size(), res);
   endtask

   task automatic check_encoding();
      encoding_type exp_r;
      logic         bad;
      results_seen++;
      if (expected_encodings.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("result beat %0d arrived with no encode waiting: code %0d byte %02h",
                     results_seen, rsp_code, rsp_packed_byte);
         end
      end else begin
         exp_r = expected_encodings.pop_front();
         bad   = (rsp_code !== exp_r.code) || (rsp_packed_byte !== exp_r.packed_byte) ||
                 (rsp_byte_ready !== exp_r.byte_ready) ||
                 (rsp_correction !== exp_r.correction) ||
                 (rsp_vector_done !== exp_r.vector_done);
         if (bad) begin
            failures++;
            if (failures <= 10) begin
               $display("result beat %0d mismatch: expected code %0d byte %02h %s",
                        results_seen, exp_r.code, exp_r.packed_byte, "");
               $display("   expected ready %0b corr %0d done %0b",
                        exp_r.byte_ready, exp_r.correction, exp_r.vector_done);
               $display("   got code %0d byte %02h ready %0b corr %0d done %0b",
                        rsp_code, rsp_packed_byte, rsp_byte_ready, rsp_correction,
                        rsp_vector_done);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_encodings.delete();
         dot_acc     = 0;
         nib_pending = 1'b0;
         nib_low     = 4'h0;
         wide_mode   = rsqe_pkg::WIDE_CODES_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_encoding();
         end
         if (csr_valid && csr_ready) begin
            wide_mode = csr_wide_codes;
         end
         if (req_valid && !req_stall) begin
            if (req_op == rsqe_pkg::OP_ENCODE) begin
               predict_encoding(req_target_value, req_recon_value, req_last_dim);
            end else if (req_table_index < TABLE_DEPTH) begin
               centroid_mirror[req_table_index] = req_table_value;
            end
         end
      end
      pending_results <= expected_encodings.size();
      mismatch_count  <= failures;
   end

endmodule

[bench/residual_scalar_quantize_encoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Residual scalar quantize encoder testbench
// Loads centroid tables of several shapes, then sends directed encode beats
// for the field extremes, midpoint ties, nibble flushing, a mode change in the
// middle of a vector and accumulator saturation, followed by random vectors in
// both code widths with random gaps and result stalls. A separate checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module residual_scalar_quantize_encoder_unit_tb;

   typedef enum int {
      SHAPE_SPREAD,
      SHAPE_DENSE,
      SHAPE_FLAT_LOW,
      SHAPE_FLAT_HIGH,
      SHAPE_SHUFFLED
   } table_shape_type;

   localparam logic MODE_NARROW = 1'b0;
   localparam logic MODE_WIDE   = 1'b1;
   localparam logic signed [rsqe_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [rsqe_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam int ITEM_GOAL      = 1700;
   localparam int QUIET_FROM     = 1450;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_wide_codes = 1'b0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = rsqe_pkg::OP_LOAD;
   logic [rsqe_pkg::INDEX_W-1:0] req_table_index = '0;
   logic signed [rsqe_pkg::VALUE_W-1:0] req_table_value = '0;
   logic signed [rsqe_pkg::VALUE_W-1:0] req_target_value = '0;
   logic signed [rsqe_pkg::VALUE_W-1:0] req_recon_value = '0;
   logic req_last_dim = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [rsqe_pkg::CODE_W-1:0] rsp_code;
   logic [rsqe_pkg::CODE_W-1:0] rsp_packed_byte;
   logic rsp_byte_ready;
   logic signed [rsqe_pkg::CORR_W-1:0] rsp_correction;
   logic rsp_vector_done;

   int mismatch_count;
   int pending_results;

   logic signed [rsqe_pkg::VALUE_W-1:0] centroid_shadow [256];
   logic wide_shadow = rsqe_pkg::WIDE_CODES_RESET;
   logic quiet = 1'b0;
   int   idle_odds = 4;
   int   beats_sent;
   int   loads_sent;
   int   narrow_beats;
   int   wide_beats;
   int   vectors_closed;
   int   csr_writes;
   int   phase_count;
   int   stall_left;
   logic stall_rest;
   int   stuck_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   residual_scalar_quantize_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wide_codes   (csr_wide_codes),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .req_target_value (req_target_value),
      .req_recon_value  (req_recon_value),
      .req_last_dim     (req_last_dim),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code         (rsp_code),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_byte_ready   (rsp_byte_ready),
      .rsp_correction   (rsp_correction),
      .rsp_vector_done  (rsp_vector_done)
   );

   rsqe_encode_checker encode_check (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wide_codes   (csr_wide_codes),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_table_index  (req_table_index),
      .req_table_value  (req_table_value),
      .req_target_value (req_target_value),
      .req_recon_value  (req_recon_value),
      .req_last_dim     (req_last_dim),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code         (rsp_code),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_byte_ready   (rsp_byte_ready),
      .rsp_correction   (rsp_correction),
      .rsp_vector_done  (rsp_vector_done),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results)
   );

   // Result stalls come in random bursts, and each burst ends with a stall-free rest.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         stall_rest = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_rest) begin
         stall_rest = 1'b0;
         rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         stall_rest = 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_beat(input logic op, input logic [rsqe_pkg::INDEX_W-1:0] index,
                            input logic signed [rsqe_pkg::VALUE_W-1:0] tvalue,
                            input logic signed [rsqe_pkg::VALUE_W-1:0] target,
                            input logic signed [rsqe_pkg::VALUE_W-1:0] recon,
                            input logic last);
      int gap;
      if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op           <= op;
      req_table_index  <= index;
      req_table_value  <= tvalue;
      req_target_value <= target;
      req_recon_value  <= recon;
      req_last_dim     <= last;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (op == rsqe_pkg::OP_ENCODE) begin
         if (wide_shadow) begin
            wide_beats++;
         end else begin
            narrow_beats++;
         end
         if (last) begin
            vectors_closed++;
         end
      end else begin
         loads_sent++;
         centroid_shadow[index] = tvalue;
      end
      if (beats_sent >= QUIET_FROM) begin
         quiet <= 1'b1;
      end
   endtask

   task automatic send_encode(input logic signed [rsqe_pkg::VALUE_W-1:0] target,
                              input logic signed [rsqe_pkg::VALUE_W-1:0] recon,
                              input logic last);
      send_beat(rsqe_pkg::OP_ENCODE, (rsqe_pkg::INDEX_W)'($urandom), $urandom,
                target, recon, last);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic wide);
      drain_and_settle();
      csr_wide_codes <= wide;
      csr_valid      <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      wide_shadow = wide;
      csr_writes++;
   endtask

   // Sorted shapes use even values so that every neighbor pair has an exact midpoint.
   task automatic fill_table(input table_shape_type shape, input int count);
      longint level;
      longint stride_max;
      logic signed [rsqe_pkg::VALUE_W-1:0] v;
      int i;
      stride_max = longint'(64'h1_0000_0000) / count;
      level      = (shape == SHAPE_DENSE) ? -(longint'(count) * 2048)
                                          : -longint'(64'h8000_0000) +
                                            2 * longint'($urandom_range(0, 1048575));
      for (i = 0; i < count; i++) begin
         case (shape)
            SHAPE_SPREAD, SHAPE_DENSE: begin
               v = level[rsqe_pkg::VALUE_W-1:0];
               if ($urandom_range(0, 15) != 0) begin
                  level = level + ((shape == SHAPE_DENSE) ?
                                   2 * longint'($urandom_range(0, 2047)) :
                                   2 * longint'($urandom_range(0, int'(stride_max) - 1)));
               end
               if (level > 2147483646) begin
                  level = 2147483646;
               end
            end
            SHAPE_FLAT_LOW:  v = VAL_MIN;
            SHAPE_FLAT_HIGH: v = VAL_MAX;
            default:         v = $urandom;
         endcase
         send_beat(rsqe_pkg::OP_LOAD, i[rsqe_pkg::INDEX_W-1:0], v, $urandom, $urandom,
                   1'($urandom_range(0, 1)));
      end
   endtask

   function automatic logic signed [rsqe_pkg::VALUE_W-1:0] small_operand();
      int s;
      s = int'($urandom_range(0, 2097151)) - 1048576;
      return s;
   endfunction

   function automatic logic signed [rsqe_pkg::VALUE_W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3, 4, 5: return $urandom;
         default: return small_operand();
      endcase
   endfunction

   function automatic longint midpoint_of(int m);
      return (longint'(centroid_shadow[m]) + longint'(centroid_shadow[m + 1])) >>> 1;
   endfunction

   task automatic send_dimension(input logic last);
      logic signed [rsqe_pkg::VALUE_W-1:0] target;
      logic signed [rsqe_pkg::VALUE_W-1:0] recon;
      longint half;
      longint t;
      int m;
      target = pick_operand();
      recon  = pick_operand();
      if ($urandom_range(0, 5) == 0) begin
         m     = $urandom_range(0, wide_shadow ? 254 : 14);
         half  = midpoint_of(m);
         recon = small_operand();
         t     = half + longint'(recon);
         if (t >= longint'(VAL_MIN) && t <= longint'(VAL_MAX)) begin
            target = t[rsqe_pkg::VALUE_W-1:0];
         end else begin
            recon  = '0;
            target = half[rsqe_pkg::VALUE_W-1:0];
         end
      end
      send_encode(target, recon, last);
   endtask

   // An open vector ends without its last dimension and runs on into the next one.
   task automatic send_vector(input int dims, input logic closed);
      int i;
      for (i = 0; i < dims; i++) begin
         if ($urandom_range(0, 24) == 0) begin
            send_beat(rsqe_pkg::OP_LOAD, (rsqe_pkg::INDEX_W)'($urandom), $urandom,
                      $urandom, $urandom, 1'($urandom_range(0, 1)));
         end
         send_dimension(closed && i == dims - 1);
      end
   endtask

   initial begin
      longint half;
      int i;
      int dims;
      int phase_end;
      table_shape_type shape;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      fill_table(SHAPE_SPREAD, 256);
      send_encode(VAL_MAX, VAL_MIN, 1'b0);
      send_encode(VAL_MIN, VAL_MAX, 1'b0);
      send_encode('0, '0, 1'b0);
      half = midpoint_of(127);
      send_encode(half[rsqe_pkg::VALUE_W-1:0], '0, 1'b0);
      half = midpoint_of(254);
      send_encode(half[rsqe_pkg::VALUE_W-1:0] - 1, -32'sd1, 1'b0);
      send_encode(VAL_MAX, VAL_MAX, 1'b1);

      write_mode(MODE_NARROW);
      fill_table(SHAPE_DENSE, 16);
      send_encode(VAL_MAX, VAL_MIN, 1'b0);
      send_encode(VAL_MIN, VAL_MAX, 1'b0);
      send_encode('0, '0, 1'b1);
      send_vector(2, 1'b1);
      send_vector(1, 1'b1);

      send_encode(small_operand(), small_operand(), 1'b0);
      write_mode(MODE_WIDE);
      send_encode(small_operand(), small_operand(), 1'b1);

      write_mode(MODE_NARROW);
      fill_table(SHAPE_FLAT_LOW, 16);
      for (i = 0; i < 5; i++) begin
         send_encode(VAL_MAX, VAL_MIN, i == 4);
      end
      fill_table(SHAPE_FLAT_HIGH, 16);
      for (i = 0; i < 5; i++) begin
         send_encode(VAL_MAX, VAL_MIN, i == 4);
      end

      while (beats_sent < ITEM_GOAL) begin
         phase_count++;
         write_mode(1'($urandom_range(0, 1)));
         case ($urandom_range(0, 3))
            0:       idle_odds = 0;
            1:       idle_odds = 2;
            2:       idle_odds = 5;
            default: idle_odds = 10;
         endcase
         shape = table_shape_type'($urandom_range(0, 4));
         if (wide_shadow && $urandom_range(0, 5) == 0) begin
            fill_table(shape, 256);
         end else if (!wide_shadow && $urandom_range(0, 1) == 0) begin
            fill_table(shape, 16);
         end
         phase_end = beats_sent + $urandom_range(60, 160);
         while (beats_sent < phase_end && beats_sent < ITEM_GOAL) begin
            dims = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            send_vector(dims, $urandom_range(0, 7) != 0);
         end
      end

      drain_and_settle();
      $display("covered %0d table loads and %0d encode beats (%0d narrow, %0d wide)",
               loads_sent, narrow_beats + wide_beats, narrow_beats, wide_beats);
      $display("%0d vectors closed, mode register written %0d times over %0d random phases",
               vectors_closed, csr_writes, phase_count);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
